[sv/euler_to_quaternion_assert.svh]
// Assertion macros for the Euler-to-quaternion converter.
// Depends on nothing; included by the top level.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define E2Q_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define E2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/e2q_pkg.sv]
// Shared constants and types for the Euler-to-quaternion converter.
// Depends on nothing.
package e2q_pkg;
  localparam int AngleBits = 16;
  localparam int CompBits  = 16;
  localparam int Stages    = 16;
  localparam int Lanes     = 3;
  localparam int WW        = 36;   // CORDIC datapath width, Q2.30 plus headroom
  localparam int PW        = 34;   // sine/cosine width
  localparam int SumW      = 36;

  localparam logic signed [WW-1:0] HalfPi  = 36'sd1686629713;
  localparam logic signed [WW-1:0] Pi      = 36'sd3373259426;
  localparam logic signed [WW-1:0] InvGain = 36'sd652032874;

  typedef logic signed [AngleBits-1:0] angle_t;
  typedef logic signed [CompBits-1:0]  comp_t;
  typedef logic signed [PW-1:0]        trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sincos_t;

  function automatic logic signed [WW-1:0] atan_q30(input int k);
    logic [31:0] t;
    case (k)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
      30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return $signed({{(WW-32){1'b0}}, t});
  endfunction

  // Round-half-up product of two Q2.30 values.
  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [2*PW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return trig_t'(p >>> 30);
  endfunction
endpackage

[sv/e2q_if.sv]
// Valid/ready channel interfaces for angle and quaternion words.
// Depends on e2q_pkg.
interface e2q_angle_if;
  import e2q_pkg::*;
  logic   valid;
  logic   ready;
  angle_t roll;
  angle_t pitch;
  angle_t yaw;
  modport source (output valid, roll, pitch, yaw, input ready);
  modport sink (input valid, roll, pitch, yaw, output ready);
endinterface

interface e2q_quat_if;
  import e2q_pkg::*;
  logic  valid;
  logic  ready;
  comp_t q_w;
  comp_t q_x;
  comp_t q_y;
  comp_t q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

[sv/e2q_cordic.sv]
// One pipelined rotation-mode CORDIC lane: angle in, half-angle sin/cos out.
// Depends on e2q_pkg. Registered input fold, then the rotation stages; advances on en_i.
module e2q_cordic (
  input  logic             clk_i,
  input  logic             en_i,
  input  e2q_pkg::angle_t  angle_i,
  output e2q_pkg::sincos_t sc_o
);
  import e2q_pkg::*;

  logic signed [WW-1:0] x_q [Stages+1];
  logic signed [WW-1:0] y_q [Stages+1];
  logic signed [WW-1:0] z_q [Stages+1];
  logic                 f_q [Stages+1];

  logic signed [WW-1:0] h;
  // Halve the angle into Q2.30 and fold it into +-pi/2.
  always_comb begin
    h = WW'(angle_i) <<< (32 - AngleBits);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= InvGain;
      y_q[0] <= '0;
      if (h > HalfPi) begin
        z_q[0] <= h - Pi;
        f_q[0] <= 1'b1;
      end else if (h < -HalfPi) begin
        z_q[0] <= h + Pi;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= h;
        f_q[0] <= 1'b0;
      end
    end
  end

  // Rotate one micro-angle per stage.
  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> (i % 32));
          y_q[i+1] <= y_q[i] + (x_q[i] >>> (i % 32));
          z_q[i+1] <= z_q[i] - atan_q30(i % 32);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> (i % 32));
          y_q[i+1] <= y_q[i] - (x_q[i] >>> (i % 32));
          z_q[i+1] <= z_q[i] + atan_q30(i % 32);
        end
      end
    end
  end

  assign sc_o.c = f_q[Stages] ? trig_t'(-x_q[Stages]) : trig_t'(x_q[Stages]);
  assign sc_o.s = f_q[Stages] ? trig_t'(-y_q[Stages]) : trig_t'(y_q[Stages]);
endmodule

[sv/e2q_merge.sv]
// Merge stage: triple products of the three lanes into quaternion words.
// Depends on e2q_pkg. Three register stages, advances on en_i.
module e2q_merge (
  input  logic             clk_i,
  input  logic             en_i,
  input  e2q_pkg::sincos_t r_i,
  input  e2q_pkg::sincos_t p_i,
  input  e2q_pkg::sincos_t y_i,
  output e2q_pkg::comp_t   w_o,
  output e2q_pkg::comp_t   x_o,
  output e2q_pkg::comp_t   y_o,
  output e2q_pkg::comp_t   z_o
);
  import e2q_pkg::*;

  function automatic comp_t to_comp(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    logic signed [SumW-1:0] one;
    one = SumW'(1) <<< (CompBits - 2);
    r = (v + (SumW'(1) <<< (32 - CompBits - 1))) >>> (32 - CompBits);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return comp_t'(r);
  endfunction

  trig_t cc_q, cs_q, sc_q, ss_q, cy_q, sy_q;   // roll/pitch pairs, yaw held
  trig_t t_q [8];
  logic signed [SumW-1:0] s0, s1, s2, s3;

  // Pair roll and pitch, then multiply by yaw, then sum and round.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= mul30(r_i.c, p_i.c);
      cs_q <= mul30(r_i.c, p_i.s);
      sc_q <= mul30(r_i.s, p_i.c);
      ss_q <= mul30(r_i.s, p_i.s);
      cy_q <= y_i.c;
      sy_q <= y_i.s;
      t_q[0] <= mul30(cc_q, cy_q);
      t_q[1] <= mul30(ss_q, sy_q);
      t_q[2] <= mul30(sc_q, cy_q);
      t_q[3] <= mul30(cs_q, sy_q);
      t_q[4] <= mul30(cs_q, cy_q);
      t_q[5] <= mul30(sc_q, sy_q);
      t_q[6] <= mul30(cc_q, sy_q);
      t_q[7] <= mul30(ss_q, cy_q);
      w_o <= to_comp(s0);
      x_o <= to_comp(s1);
      y_o <= to_comp(s2);
      z_o <= to_comp(s3);
    end
  end

  always_comb begin
    s0 = SumW'(t_q[0]) + SumW'(t_q[1]);
    s1 = SumW'(t_q[2]) - SumW'(t_q[3]);
    s2 = SumW'(t_q[4]) + SumW'(t_q[5]);
    s3 = SumW'(t_q[6]) - SumW'(t_q[7]);
  end
endmodule

[sv/euler_to_quaternion.sv]
// Euler (Z-Y-X) angles to unit quaternion, three CORDIC lanes and a merge stage.
// A word passes through the CORDIC fold and rotation registers, then the merge registers.
// Throughput: one word per cycle; the whole pipeline advances when the
// output register is empty or being taken, so a stall freezes every stage.
// Reset clears the valid flags only; the datapath is not reset.
// Depends on e2q_pkg, e2q_if, e2q_cordic, e2q_merge and the assertion header.
module euler_to_quaternion (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_angle_if.sink  in_i,
  e2q_quat_if.source out_o
);
  import e2q_pkg::*;
  `include "euler_to_quaternion_assert.svh"

  localparam int Lat = Stages + 4;

  logic           en;
  logic [Lat-1:0] vld_q;
  sincos_t        sc_r, sc_p, sc_y;

  // Advance whenever the last slot is free or being taken.
  assign en          = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  e2q_cordic u_roll  (.clk_i, .en_i(en), .angle_i(in_i.roll),  .sc_o(sc_r));
  e2q_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_i.pitch), .sc_o(sc_p));
  e2q_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(in_i.yaw),   .sc_o(sc_y));

  e2q_merge u_merge (
    .clk_i, .en_i(en), .r_i(sc_r), .p_i(sc_p), .y_i(sc_y),
    .w_o(out_o.q_w), .x_o(out_o.q_x), .y_o(out_o.q_y), .z_o(out_o.q_z)
  );

  `E2Q_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_o.valid, in_i.ready)
  `E2Q_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.q_w) && $stable(out_o.q_z))
  `E2Q_ASSERT_IMP(a_w_range, clk_i, rst_ni, out_o.valid, out_o.q_w <= 16'sd16384 && out_o.q_w >= -16'sd16384)
endmodule

[bench/e2q_quat_checker.sv]
// Checker for the Euler-to-quaternion converter: watches both channels,
// predicts each quaternion word from the angle word and compares. Depends on e2q_pkg, e2q_if.
module e2q_quat_checker (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_angle_if in_i,
  e2q_quat_if  out_o,
  output int   fail_count_o,
  output int   pending_o,
  output int   quat_seen_o
);
  import e2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  quat_t expected_quats[$];
  int    fails;
  int    seen;

  localparam longint HalfPiQ30  = 64'sd1686629713;
  localparam longint PiQ30      = 64'sd3373259426;
  localparam longint InvGainQ30 = 64'sd652032874;

  function automatic longint atan_entry(input int k);
    longint tab[16] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
                        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
                        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
                        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF};
    return tab[k];
  endfunction

  // Round-half-up product of two Q2.30 values; >>> on longint floors.
  function automatic longint prod_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Half angle in Q2.30, then rotate a CORDIC vector to it.
  function automatic void half_sincos(input angle_t ang, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = InvGainQ30;
    y = 0;
    z = longint'(ang) * 65536;
    flip = 0;
    if (z > HalfPiQ30) begin
      z -= PiQ30;
      flip = 1;
    end else if (z < -HalfPiQ30) begin
      z += PiQ30;
      flip = 1;
    end
    for (int k = 0; k < Stages; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(k);
      end else begin
        x += dx; y -= dy; z += atan_entry(k);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Round to Q1.14 and clamp to plus or minus one.
  function automatic comp_t round_component(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return comp_t'(r);
  endfunction

  function automatic longint tri_prod(input longint a, input longint b, input longint c);
    return prod_q30(prod_q30(a, b), c);
  endfunction

  function automatic quat_t predict_quat(input angle_t r, input angle_t p, input angle_t y);
    longint cr, sr, cp, sp, cy, sy;
    quat_t  q;
    half_sincos(r, cr, sr);
    half_sincos(p, cp, sp);
    half_sincos(y, cy, sy);
    q.w = round_component(tri_prod(cr, cp, cy) + tri_prod(sr, sp, sy));
    q.x = round_component(tri_prod(sr, cp, cy) - tri_prod(cr, sp, sy));
    q.y = round_component(tri_prod(cr, sp, cy) + tri_prod(sr, cp, sy));
    q.z = round_component(tri_prod(cr, cp, sy) - tri_prod(sr, sp, cy));
    return q;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  // Queue a prediction per accepted angle word; compare each quaternion word.
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t want;
    if (!rst_ni) begin
      fails = 0;
      seen = 0;
    end else begin
      if (in_i.valid && in_i.ready)
        expected_quats.push_back(predict_quat(in_i.roll, in_i.pitch, in_i.yaw));
      if (out_o.valid && out_o.ready) begin
        seen++;
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_quats.pop_front();
          if (out_o.q_w !== want.w) report_mismatch("q_w", out_o.q_w, want.w);
          if (out_o.q_x !== want.x) report_mismatch("q_x", out_o.q_x, want.x);
          if (out_o.q_y !== want.y) report_mismatch("q_y", out_o.q_y, want.y);
          if (out_o.q_z !== want.z) report_mismatch("q_z", out_o.q_z, want.z);
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = expected_quats.size();
  assign quat_seen_o  = seen;
endmodule

[bench/tb_euler_to_quaternion.sv]
// Testbench top for the Euler-to-quaternion converter: drives angle words,
// stalls the result side, and gives the verdict. Depends on e2q_pkg, e2q_if, e2q_quat_checker.
module tb_euler_to_quaternion;
  import e2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 1030;
  localparam int CycleLimit  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, quat_seen;
  int   sent = 0;

  e2q_angle_if angle_ch ();
  e2q_quat_if  quat_ch ();

  euler_to_quaternion uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (angle_ch),
    .out_o (quat_ch)
  );

  e2q_quat_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (angle_ch),
    .out_o       (quat_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .quat_seen_o (quat_seen)
  );

  always #10 clk_i = ~clk_i;

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Gap length: mostly short, a few long, many zero.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random, with quiet stretches.
  initial begin
    int g;
    quat_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        quat_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      quat_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Drive one word and hold it until taken.
  task automatic send_angles(input angle_t r, input angle_t p, input angle_t y);
    angle_ch.valid <= 1'b1;
    angle_ch.roll  <= r;
    angle_ch.pitch <= p;
    angle_ch.yaw   <= y;
    @(posedge clk_i);
    while (!angle_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic idle_sender();
    int g;
    g = pick_gap();
    if (g > 0) begin
      angle_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 9))
      0: return angle_t'(16'sh8000);
      1: return angle_t'(16'sh7FFF);
      2: return angle_t'($urandom_range(0, 40) - 20);
      // Around half angle of plus or minus pi/2, where the fold kicks in.
      3: return angle_t'(($urandom_range(0, 1) ? 25736 : -25736)
                         + $urandom_range(0, 16) - 8);
      default: return angle_t'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    angle_t dirs[] = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000,
                       16'sh6488, 16'sh6489, 16'sh9B78, 16'sh9B77, 16'sh3244,
                       16'shCDBC, 16'sh5555, 16'shAAAA};
    int t;
    angle_ch.valid = 1'b0;
    angle_ch.roll  = '0;
    angle_ch.pitch = '0;
    angle_ch.yaw   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes and near the fold points mixed across lanes, then each lane alone.
    foreach (dirs[i])
      send_angles(dirs[i], dirs[(i + 4) % dirs.size()], dirs[(i + 7) % dirs.size()]);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh6488, 16'sh0000, 16'sh0000);
    send_angles(16'sh0000, 16'sh6488, 16'sh0000);
    send_angles(16'sh0000, 16'sh0000, 16'sh9B78);
    send_angles(16'sh3244, 16'shCDBC, 16'sh3244);

    // Hold off until the pipeline has drained; let the last push land first.
    angle_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (t = 0; t < RandomWords; t++) begin
      if (t > 300) idle_sender();
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    angle_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d angle words, checked %0d quaternion words", sent, quat_seen);
    $display("with both sides stalling, fold points and full-scale angles included.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/e2q_pkg.sv
sv/e2q_if.sv
sv/e2q_cordic.sv
sv/e2q_merge.sv
sv/euler_to_quaternion.sv
bench/e2q_quat_checker.sv
bench/tb_euler_to_quaternion.sv
